[hdl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

[hdl/bsff_pkg.sv]
// ----------------------------------------------------------------------------
// bsff_pkg
// types, constants and helpers of the buddy split first-fit allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bsff_pkg;

    localparam int ARENA_LOG2_MAX  = 16;
    localparam int HEADER_BYTES    = 16;
    localparam int MIN_BLOCK_BYTES = 16;
    localparam int MIN_LOG2        = $clog2(MIN_BLOCK_BYTES);
    localparam int SLOT_BITS       = ARENA_LOG2_MAX - MIN_LOG2;
    localparam int SLOT_COUNT      = 1 << SLOT_BITS;
    localparam int LOG2_W          = 5;
    localparam int COUNT_W         = SLOT_BITS + 1;
    localparam int REQ_W           = 16;
    localparam int CFG_W           = 17;
    localparam int NEED_W          = REQ_W + 2;
    localparam int OFFSET_W        = 16;

    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [LOG2_W-1:0]    log2_t;
    typedef logic [COUNT_W-1:0]   count_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_READ,
        ST_CHECK,
        ST_SPLIT_CHK,
        ST_SPLIT_W1,
        ST_SPLIT_W2,
        ST_UNLINK,
        ST_RESULT
    } state_t;

    // rounded-up log2 of the requested arena, clamped to the legal range
    function automatic log2_t arena_log2(input logic [CFG_W-1:0] v);
        log2_t l;
        l = '0;
        for (int i = 0; i < CFG_W; i++)
        begin
            if ((CFG_W+1)'(1 << i) < {1'b0, v})
            begin
                l = log2_t'(i + 1);
            end
        end
        if (l < log2_t'(MIN_LOG2))
        begin
            l = log2_t'(MIN_LOG2);
        end
        if (l > log2_t'(ARENA_LOG2_MAX))
        begin
            l = log2_t'(ARENA_LOG2_MAX);
        end
        return l;
    endfunction

endpackage

`default_nettype wire

[hdl/buddy_split_first_fit_allocator_top.sv]
// ----------------------------------------------------------------------------
// buddy_split_first_fit_allocator_top
// first-fit allocator over a circular free list with buddy-style halving
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------
//  request | req_valid / req_stall | request_bytes
//  result  | rsp_valid / rsp_stall | granted, payload_offset
//  config  | cfg_write             | arena_bytes
//
//  one request at a time: accept, then ST_READ and ST_CHECK per free region visited
//  on the walk, ST_SPLIT_CHK, ST_SPLIT_W1 and ST_SPLIT_W2 per halving split plus a
//  final split check, ST_UNLINK, and ST_RESULT to load the result beat
//  walk and split share one list memory port
//  after reset or a config write, ST_INIT rewrites slot 0 before the next beat
//  a new request beat is taken while a result beat still waits on rsp_stall
//  the result waits in its own register until rsp_stall drops
`default_nettype none

module buddy_split_first_fit_allocator_top (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                req_valid,
    output logic                               req_stall,
    input  wire  [bsff_pkg::REQ_W-1:0]         request_bytes,
    output logic                               rsp_valid,
    input  wire                                rsp_stall,
    output logic                               granted,
    output logic [bsff_pkg::OFFSET_W-1:0]      payload_offset,
    input  wire                                cfg_write,
    input  wire  [bsff_pkg::CFG_W-1:0]         arena_bytes
);
    import bsff_pkg::*;

    // list memories, one entry per minimum block
    slot_t next_mem [SLOT_COUNT];
    slot_t prev_mem [SLOT_COUNT];
    log2_t size_mem [SLOT_COUNT];

    state_t state_reg, state_next;
    log2_t  arena_log2_reg;
    logic   init_pend_reg, init_pend_next;
    count_t count_reg, count_next;
    slot_t  rover_reg, rover_next;
    count_t steps_reg, steps_next;
    slot_t  cur_reg, cur_next;
    slot_t  nx_reg, nx_next;
    slot_t  pv_reg, pv_next;
    log2_t  l_reg, l_next;
    logic [REQ_W-1:0] n_reg, n_next;
    logic   res_grant_reg, res_grant_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   granted_reg, granted_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;

    // registered read data, address is the current slot
    slot_t next_q, prev_q;
    log2_t size_q;

    // write ports
    logic  next_we, prev_we, size_we;
    slot_t next_wa, prev_wa, size_wa;
    slot_t next_wd, prev_wd;
    log2_t size_wd;

    // shared compare operands
    log2_t             blk_log2;
    logic [NEED_W-1:0] blk_bytes;
    logic [NEED_W-1:0] need_fit;
    logic [NEED_W-1:0] need_lone;
    logic [NEED_W-1:0] need_split;
    slot_t             up_slot;

    always_ff @(posedge clk)
    begin
        next_q <= next_mem[cur_reg];
        prev_q <= prev_mem[cur_reg];
        size_q <= size_mem[cur_reg];
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (size_we)
        begin
            size_mem[size_wa] <= size_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            arena_log2_reg <= log2_t'(ARENA_LOG2_MAX);
            init_pend_reg  <= 1'b1;
            count_reg      <= count_t'(1);
            rover_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write)
            begin
                // reinitialise: one free region at offset 0
                arena_log2_reg <= arena_log2(arena_bytes);
                init_pend_reg  <= 1'b1;
                count_reg      <= count_t'(1);
                rover_reg      <= '0;
            end
            else
            begin
                init_pend_reg <= init_pend_next;
                count_reg     <= count_next;
                rover_reg     <= rover_next;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        steps_reg     <= steps_next;
        cur_reg       <= cur_next;
        nx_reg        <= nx_next;
        pv_reg        <= pv_next;
        l_reg         <= l_next;
        n_reg         <= n_next;
        res_grant_reg <= res_grant_next;
        granted_reg   <= granted_next;
        offset_reg    <= offset_next;
    end

    always_comb
    begin
        // split check looks at the held size, the walk at the memory read
        blk_log2    = (state_reg == ST_SPLIT_CHK) ? l_reg : size_q;
        blk_bytes   = '0;
        blk_bytes[blk_log2] = 1'b1;
        need_fit    = NEED_W'(n_reg) + NEED_W'(HEADER_BYTES);
        need_lone   = NEED_W'(n_reg) + NEED_W'(2 * HEADER_BYTES);
        need_split  = (NEED_W'(n_reg) + NEED_W'(HEADER_BYTES)) << 1;
        // upper half sits half a block further on
        up_slot     = cur_reg + (slot_t'(1) << (l_reg - log2_t'(MIN_LOG2 + 1)));
    end

    always_comb
    begin
        state_next     = state_reg;
        init_pend_next = init_pend_reg;
        count_next     = count_reg;
        rover_next     = rover_reg;
        steps_next     = steps_reg;
        cur_next       = cur_reg;
        nx_next        = nx_reg;
        pv_next        = pv_reg;
        l_next         = l_reg;
        n_next         = n_reg;
        res_grant_next = res_grant_reg;
        rsp_valid_next = rsp_valid_reg;
        granted_next   = granted_reg;
        offset_next    = offset_reg;
        req_stall      = 1'b1;
        next_we = 1'b0; next_wa = '0; next_wd = '0;
        prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
        size_we = 1'b0; size_wa = '0; size_wd = '0;

        // result beat leaves its register
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (init_pend_reg)
                begin
                    state_next = ST_INIT;
                end
                else
                begin
                    req_stall = 1'b0;
                    if (req_valid)
                    begin
                        n_next     = request_bytes;
                        cur_next   = rover_reg;
                        steps_next = '0;
                        if (count_reg == '0)
                        begin
                            res_grant_next = 1'b0;
                            state_next     = ST_RESULT;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_INIT:
            begin
                next_we = 1'b1; next_wa = '0; next_wd = '0;
                prev_we = 1'b1; prev_wa = '0; prev_wd = '0;
                size_we = 1'b1; size_wa = '0; size_wd = arena_log2_reg;
                init_pend_next = 1'b0;
                state_next     = ST_IDLE;
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (count_reg == count_t'(1))
                begin
                    // lone region needs room for two headers
                    if (blk_bytes > need_lone)
                    begin
                        state_next = ST_SPLIT_CHK;
                    end
                    else
                    begin
                        res_grant_next = 1'b0;
                        state_next     = ST_RESULT;
                    end
                end
                else if (blk_bytes >= need_fit)
                begin
                    state_next = ST_SPLIT_CHK;
                end
                else if (steps_reg + count_t'(1) >= count_reg)
                begin
                    res_grant_next = 1'b0;
                    state_next     = ST_RESULT;
                end
                else
                begin
                    cur_next   = next_q;
                    steps_next = steps_reg + count_t'(1);
                    state_next = ST_READ;
                end
                l_next  = size_q;
                nx_next = next_q;
                pv_next = prev_q;
            end
            ST_SPLIT_CHK:
            begin
                if (l_reg == '0 || blk_bytes < need_split
                    || l_reg < log2_t'(MIN_LOG2 + 1))
                begin
                    state_next = ST_UNLINK;
                end
                else
                begin
                    state_next = ST_SPLIT_W1;
                end
            end
            ST_SPLIT_W1:
            begin
                size_we = 1'b1; size_wa = cur_reg; size_wd = l_reg - log2_t'(1);
                next_we = 1'b1; next_wa = cur_reg; next_wd = up_slot;
                prev_we = 1'b1; prev_wa = nx_reg;  prev_wd = up_slot;
                if (nx_reg == cur_reg)
                begin
                    pv_next = up_slot;
                end
                state_next = ST_SPLIT_W2;
            end
            ST_SPLIT_W2:
            begin
                size_we = 1'b1; size_wa = up_slot; size_wd = l_reg - log2_t'(1);
                next_we = 1'b1; next_wa = up_slot; next_wd = nx_reg;
                prev_we = 1'b1; prev_wa = up_slot; prev_wd = cur_reg;
                nx_next    = up_slot;
                l_next     = l_reg - log2_t'(1);
                count_next = count_reg + count_t'(1);
                state_next = ST_SPLIT_CHK;
            end
            ST_UNLINK:
            begin
                next_we = 1'b1; next_wa = pv_reg; next_wd = nx_reg;
                prev_we = 1'b1; prev_wa = nx_reg; prev_wd = pv_reg;
                count_next     = count_reg - count_t'(1);
                rover_next     = nx_reg;
                res_grant_next = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    granted_next   = res_grant_reg;
                    offset_next    = res_grant_reg
                        ? OFFSET_W'({cur_reg, MIN_LOG2'(0)} + (SLOT_BITS+MIN_LOG2)'(HEADER_BYTES))
                        : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid      = rsp_valid_reg;
    assign granted        = granted_reg;
    assign payload_offset = offset_reg;

endmodule

`default_nettype wire

[hdl/bsff_checker.sv]
// ----------------------------------------------------------------------------
// bsff_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bsff_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        req_valid,
    input wire        req_stall,
    input wire        rsp_valid,
    input wire        rsp_stall,
    input wire        granted,
    input wire [15:0] payload_offset
);

    // held result beat keeps its payload
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(granted) && $stable(payload_offset))
    // refused request carries a zero offset
    `ASSERT_IMPLY(a_fail_zero, clk, rst_n, rsp_valid && !granted, payload_offset == 16'd0)
    // granted offsets sit on a block boundary past the header
    `ASSERT_IMPLY(a_align, clk, rst_n, rsp_valid && granted, payload_offset[3:0] == 4'd0)
    // one request at a time
    `ASSERT_NEXT(a_busy, clk, rst_n, req_valid && !req_stall, req_stall)

endmodule

bind buddy_split_first_fit_allocator_top bsff_checker u_bsff_checker (.*);

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the buddy split first-fit allocator
// ----------------------------------------------------------------------------
// requests go out through a queue-fed driver. Each accepted request beat runs
// through a local model of the free list, which splits, unlinks and moves the
// rover, and the result it expects is queued. A monitor checks every result
// beat against the oldest expected one. Phases reprogram the arena size while
// the block is idle. Random idle gaps on the request channel and stall bursts
// on the result channel are applied, and the last phase runs without them.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bsff_pkg::*;

    typedef struct {
        logic                granted;
        logic [OFFSET_W-1:0] offset;
    } grant_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [REQ_W-1:0]    request_bytes = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic                granted;
    logic [OFFSET_W-1:0] payload_offset;
    logic                cfg_write = 1'b0;
    logic [CFG_W-1:0]    arena_bytes = '0;

    buddy_split_first_fit_allocator_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .request_bytes  (request_bytes),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .granted        (granted),
        .payload_offset (payload_offset),
        .cfg_write      (cfg_write),
        .arena_bytes    (arena_bytes)
    );

    // local copy of the free list
    slot_t fl_next [SLOT_COUNT];
    slot_t fl_prev [SLOT_COUNT];
    log2_t fl_log2 [SLOT_COUNT];
    bit    fl_free [SLOT_COUNT];
    slot_t rover;
    int    free_regions;
    int    arena_size;

    logic [REQ_W-1:0] pending_requests [$];
    grant_t           expected_grants  [$];
    int               issued_count   = 0;
    int               accepted_count = 0;
    int               error_count    = 0;
    bit               bursts_on      = 1'b1;
    int               long_holds_asked = 0;
    int               long_holds_done  = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // rebuild the arena as a single free region at offset 0
    function automatic void model_arena_init(input logic [CFG_W-1:0] v);
        int l;
        l = 0;
        while (l < 40 && (longint'(1) << l) < longint'(v))
        begin
            l++;
        end
        if (l < MIN_LOG2)
        begin
            l = MIN_LOG2;
        end
        if (l > ARENA_LOG2_MAX)
        begin
            l = ARENA_LOG2_MAX;
        end
        fl_next[0] = '0;
        fl_prev[0] = '0;
        fl_log2[0] = log2_t'(l);
        fl_free[0] = 1'b1;
        rover = '0;
        free_regions = 1;
        arena_size = 1 << l;
    endfunction

    // first-fit walk from the rover, halving, unlink
    function automatic grant_t alloc_predict(input int n);
        grant_t r;
        int     cur;
        int     steps;
        int     size;
        int     l;
        int     up;
        slot_t  nx;
        slot_t  pv;
        bit     found;
        r.granted = 1'b0;
        r.offset  = '0;
        if (free_regions == 0)
        begin
            return r;
        end
        cur = rover;
        steps = 0;
        found = 1'b0;
        while (!found && steps < free_regions && steps < SLOT_COUNT)
        begin
            size = 1 << fl_log2[cur];
            if (free_regions == 1)
            begin
                // a lone region needs room for two headers
                if (size > n + 2 * HEADER_BYTES)
                begin
                    found = 1'b1;
                end
                else
                begin
                    return r;
                end
            end
            else if (size >= n + HEADER_BYTES)
            begin
                found = 1'b1;
            end
            else
            begin
                cur = fl_next[cur];
                steps++;
            end
        end
        if (!found)
        begin
            return r;
        end
        while (1)
        begin
            l = fl_log2[cur];
            size = 1 << l;
            if (l == 0 || size < 2 * (HEADER_BYTES + n))
            begin
                break;
            end
            if ((size >> 1) < MIN_BLOCK_BYTES)
            begin
                break;
            end
            up = (cur + (size >> 1) / MIN_BLOCK_BYTES) % SLOT_COUNT;
            fl_log2[cur] = log2_t'(l - 1);
            fl_log2[up]  = log2_t'(l - 1);
            fl_free[up]  = 1'b1;
            nx = fl_next[cur];
            fl_prev[nx] = slot_t'(up);
            fl_next[up] = nx;
            fl_next[cur] = slot_t'(up);
            fl_prev[up] = slot_t'(cur);
            free_regions++;
        end
        nx = fl_next[cur];
        pv = fl_prev[cur];
        fl_next[pv] = nx;
        fl_prev[nx] = pv;
        fl_free[cur] = 1'b0;
        free_regions--;
        rover = nx;
        r.granted = 1'b1;
        r.offset  = OFFSET_W'(cur * MIN_BLOCK_BYTES + HEADER_BYTES);
        return r;
    endfunction

    // request driver with random idle bursts
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            gap_left  <= 0;
        end
        else
        begin
            bit free_to_load;
            free_to_load = !req_valid || !req_stall;
            if (req_valid && !req_stall)
            begin
                expected_grants.push_back(alloc_predict(int'(request_bytes)));
                accepted_count++;
            end
            if (free_to_load)
            begin
                if (gap_left > 0)
                begin
                    gap_left  <= gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (bursts_on && $urandom_range(0, 9) == 0)
                begin
                    gap_left  <= $urandom_range(1, 15) - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    request_bytes <= pending_requests.pop_front();
                    req_valid     <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result stall: random bursts, plus long holds on request
    int stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall  <= (stall_left > 1);
        end
        else if (long_holds_done < long_holds_asked)
        begin
            // long hold so the request side backs up
            long_holds_done <= long_holds_done + 1;
            stall_left <= 400;
            rsp_stall  <= 1'b1;
        end
        else if (bursts_on && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 15);
            rsp_stall  <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            grant_t want;
            if (expected_grants.size() == 0)
            begin
                report("result beat with nothing expected");
            end
            else
            begin
                want = expected_grants.pop_front();
                if (granted !== want.granted)
                begin
                    report($sformatf("granted %b, want %b", granted, want.granted));
                end
                if (payload_offset !== want.offset)
                begin
                    report($sformatf("payload_offset %0d, want %0d",
                                     payload_offset, want.offset));
                end
            end
        end
    end

    // watchdog on cycles without any beat
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_write)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= 40000)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_request(input int n);
        pending_requests.push_back(REQ_W'(n));
        issued_count++;
    endtask

    task automatic wait_drained();
        while (accepted_count != issued_count || expected_grants.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_arena(input logic [CFG_W-1:0] v);
        wait_drained();
        // every request answers, but let the last one settle anyway
        repeat (8) @(posedge clk);
        cfg_write   <= 1'b1;
        arena_bytes <= v;
        @(posedge clk);
        cfg_write   <= 1'b0;
        model_arena_init(v);
    endtask

    // mostly sizes that fit the current arena, some across the full range
    function automatic int random_request();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            return $urandom_range(0, arena_size / 8);
        end
        else if (pick < 7)
        begin
            return $urandom_range(0, 15);
        end
        else if (pick < 8)
        begin
            return $urandom_range(0, 65535);
        end
        else
        begin
            return $urandom_range(arena_size / 2, arena_size) & 16'hFFFF;
        end
    endfunction

    logic [CFG_W-1:0] arena_plan [$];
    initial
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            fl_next[i] = '0;
            fl_prev[i] = '0;
            fl_log2[i] = '0;
            fl_free[i] = 1'b0;
        end
        model_arena_init(CFG_W'(65536));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, lone-region limit, split floor
        queue_request(0);
        queue_request(65535);
        queue_request(65504);
        queue_request(65503);
        write_arena(CFG_W'(65536));
        queue_request(1);
        queue_request(15);
        queue_request(16);
        queue_request(17);
        queue_request(32767);
        queue_request(4095);
        queue_request(0);
        queue_request(100);
        // small arena: 0 and 1 round up to the minimum, where a lone region never fits
        write_arena(CFG_W'(0));
        queue_request(0);
        write_arena(CFG_W'(1));
        queue_request(0);
        write_arena(CFG_W'(33));
        queue_request(0);
        queue_request(0);
        queue_request(0);
        // 64-byte arena: the first request splits it, the lone half left never fits
        write_arena(CFG_W'(64));
        queue_request(15);
        queue_request(15);
        queue_request(0);
        queue_request(0);
        // large arena clamps to the maximum
        write_arena(CFG_W'(131071));
        queue_request(0);
        queue_request(65535);

        // random phases across arena sizes
        arena_plan = '{CFG_W'(65536), CFG_W'(32), CFG_W'(1024), CFG_W'(65537),
                       CFG_W'(4096), CFG_W'(300), CFG_W'(131071), CFG_W'(65536)};
        foreach (arena_plan[p])
        begin
            write_arena(p == 3 ? CFG_W'($urandom_range(0, 131071)) : arena_plan[p]);
            if (p == arena_plan.size() - 1)
            begin
                bursts_on = 1'b0;
            end
            if (p == 1)
            begin
                // sender pause: one request at a time, fully drained
                for (int k = 0; k < 10; k++)
                begin
                    queue_request(random_request());
                    wait_drained();
                end
            end
            if (p == 2)
            begin
                long_holds_asked++;
            end
            for (int k = 0; k < 70; k++)
            begin
                queue_request(random_request());
            end
        end

        wait_drained();
        repeat (64) @(posedge clk);
        if (error_count == 0 && expected_grants.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+hdl
hdl/bsff_pkg.sv
hdl/buddy_split_first_fit_allocator_top.sv
hdl/bsff_checker.sv
tb/tb.sv
